FILE: design/spq_pkg.sv
package spq_pkg;

  // Field widths of one request and one result.
  localparam int ValueW = 32;
  localparam int PrioW = 16;
  localparam int StatusW = 2;
  localparam int CountOutW = 5;

  // Request codes carried on the action field.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_DONE = 2'd0;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW = 2'd2;

  // Controller states.
  typedef enum logic {
    STATE_IDLE,
    STATE_EXEC
  } spq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
  } spq_cmd_t;

endpackage

FILE: design/sorted_priority_queue_unit.sv
// Sequence: the controller captures a request on its input transfer, and the parallel
// compare-and-shift cell row applies it in the execute state, which waits while an
// older result is still stalled; the new result then goes to the result register.
// A new request is not taken until the cell row has applied the previous one.
// A new request may be taken while the previous result waits for its transfer.
// Reset (rst, synchronous, active high) empties the queue and clears out_valid.
module sorted_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic signed [spq_pkg::ValueW-1:0]    value,
  input  logic signed [spq_pkg::PrioW-1:0]     priority_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [spq_pkg::StatusW-1:0]   status,
  output logic                                 is_empty,
  output logic        [spq_pkg::CountOutW-1:0] entry_count,
  output logic signed [spq_pkg::ValueW-1:0]    front_value,
  output logic signed [spq_pkg::PrioW-1:0]     front_priority,
  output logic signed [spq_pkg::ValueW-1:0]    rear_value
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // Sequencing of capture, update and result transfer.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Sorted cell row and result register.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (action),
    .value          (value),
    .priority_req   (priority_req),
    .status         (status),
    .is_empty       (is_empty),
    .entry_count    (entry_count),
    .front_value    (front_value),
    .front_priority (front_priority),
    .rear_value     (rear_value)
  );

endmodule

FILE: design/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  spq_state_t state;
  spq_state_t state_next;
  logic       out_valid_next;
  logic       result_free;

  // The result register can take a new result when it is empty or being drained.
  assign result_free = !out_valid || !out_stall;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      STATE_IDLE: begin
        if (in_valid) begin
          state_next = STATE_EXEC;
        end
      end
      STATE_EXEC: begin
        if (result_free) begin
          state_next = STATE_IDLE;
        end
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    cmd.load_in = 1'b0;
    cmd.exec = 1'b0;
    in_stall = 1'b1;
    case (state)
      STATE_IDLE: begin
        in_stall = 1'b0;
        cmd.load_in = in_valid;
      end
      STATE_EXEC: begin
        cmd.exec = result_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // A result stays valid until its transfer completes.
  assign out_valid_next = cmd.exec ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: design/spq_datapath.sv
module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spq_pkg::spq_cmd_t                    cmd,
  input  logic                                 action,
  input  logic signed [spq_pkg::ValueW-1:0]    value,
  input  logic signed [spq_pkg::PrioW-1:0]     priority_req,
  output logic        [spq_pkg::StatusW-1:0]   status,
  output logic                                 is_empty,
  output logic        [spq_pkg::CountOutW-1:0] entry_count,
  output logic signed [spq_pkg::ValueW-1:0]    front_value,
  output logic signed [spq_pkg::PrioW-1:0]     front_priority,
  output logic signed [spq_pkg::ValueW-1:0]    rear_value
);
  import spq_pkg::*;

  localparam int CountW = $clog2(CAPACITY + 1);

  // Captured request.
  logic                     req_action;
  logic signed [ValueW-1:0] req_value;
  logic signed [PrioW-1:0]  req_prio;

  // Sorted cell row, held count and a copy of the rear value.
  logic signed [ValueW-1:0] cell_value [CAPACITY];
  logic signed [PrioW-1:0]  cell_prio [CAPACITY];
  logic signed [ValueW-1:0] cell_value_next [CAPACITY];
  logic signed [PrioW-1:0]  cell_prio_next [CAPACITY];
  logic [CountW-1:0]        held_count;
  logic [CountW-1:0]        held_count_next;
  logic signed [ValueW-1:0] rear;
  logic signed [ValueW-1:0] rear_next;

  logic [CAPACITY-1:0]  occupied;
  logic [CAPACITY-1:0]  stays;
  logic                 full;
  logic                 empty;
  logic                 insert_tail;
  logic                 do_push;
  logic                 do_pop;
  logic [StatusW-1:0]   status_next;

  // Capture the request on its input transfer.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_action <= action;
      req_value <= value;
      req_prio <= priority_req;
    end
  end

  // Each cell compares its priority with the request in parallel.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occupied[i] = CountW'(i) < held_count;
      stays[i] = occupied[i] && (cell_prio[i] <= req_prio);
    end
  end

  assign full = held_count == CountW'(CAPACITY);
  assign empty = held_count == '0;
  assign insert_tail = !(|(occupied & ~stays));
  assign do_push = (req_action == ACT_PUSH) && !full;
  assign do_pop = (req_action == ACT_POP) && !empty;

  // Insertion shifts the cells behind the new entry back by one; a pop shifts all forward.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_value_next[i] = cell_value[i];
      cell_prio_next[i] = cell_prio[i];
      if (do_push && !stays[i]) begin
        if (i == 0) begin
          cell_value_next[i] = req_value;
          cell_prio_next[i] = req_prio;
        end else if (stays[(i > 0) ? i - 1 : 0]) begin
          cell_value_next[i] = req_value;
          cell_prio_next[i] = req_prio;
        end else begin
          cell_value_next[i] = cell_value[(i > 0) ? i - 1 : 0];
          cell_prio_next[i] = cell_prio[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop && (i < CAPACITY - 1)) begin
        cell_value_next[i] = cell_value[(i < CAPACITY - 1) ? i + 1 : i];
        cell_prio_next[i] = cell_prio[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // Count, rear and status for this request.
  always_comb begin
    held_count_next = held_count;
    rear_next = rear;
    status_next = ST_DONE;
    if (req_action == ACT_PUSH) begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else begin
        held_count_next = held_count + CountW'(1);
        if (insert_tail) begin
          rear_next = req_value;
        end
      end
    end else begin
      if (empty) begin
        status_next = ST_UNDERFLOW;
      end else begin
        held_count_next = held_count - CountW'(1);
      end
    end
  end

  // Queue state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.exec) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rear <= rear_next;
      for (int i = 0; i < CAPACITY; i++) begin
        cell_value[i] <= cell_value_next[i];
        cell_prio[i] <= cell_prio_next[i];
      end
    end
  end

  // Result register; empty queues show zero payload.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= status_next;
      is_empty <= held_count_next == '0;
      entry_count <= CountOutW'(held_count_next);
      if (held_count_next == '0) begin
        front_value <= '0;
        front_priority <= '0;
        rear_value <= '0;
      end else begin
        front_value <= cell_value_next[0];
        front_priority <= cell_prio_next[0];
        rear_value <= rear_next;
      end
    end
  end

endmodule
